### sv/gcf_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the 3x3 luminance filter.
// No dependencies; imported by every module of the block.
package gcf_pkg;

    localparam int PIX_W = 16;
    localparam logic [7:0] PIX_MAX = 8'd255;

    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } gcf_col_t;

    typedef struct packed {
        gcf_col_t l;
        gcf_col_t m;
        gcf_col_t r;
    } gcf_win_t;

endpackage

### sv/gray_conv3x3_filter_unit.sv
`timescale 1ns / 1ps
// 3x3 symmetric-kernel filter over the luminance of an RGB raster stream.
// Depends on gcf_pkg, gcf_line_store, gcf_window_cell and gcf_kernel.
//
// Input channel (in_valid/in_stall): one word per pixel in raster order, action 0;
// after the last line of a frame send image_width+1 flush words (action 1).
// Output channel (out_valid/out_stall): filtered_value for each pixel, frame_last
// set on the final pixel of the frame. A pixel's result is caused by the word one
// line plus one pixel later; after that word is taken it passes the input register
// and the kernel's stages before it shows on the outputs.
// Throughput: one word per cycle while the receiver does not stall. Each word does
// one read and one write of the line stores and one shift of the three window
// cells, and the kernel behind them is fully pipelined.
// A stalled receiver holds the output word; the internal stages keep filling
// until full, then in_stall rises.
// Reset clears the counters, the window and the pipeline and loads the default
// registers; the line stores are not cleared. The configuration port must be
// written only while the block is empty; the block itself does not enforce it.
module gray_conv3x3_filter_unit
    import gcf_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    parameter int COEF_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  filtered_value,
    output logic        frame_last,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int COL_W = 11;
    localparam int ROW_W = 13;

    localparam logic [2:0] REG_WIDTH  = 3'd0;
    localparam logic [2:0] REG_HEIGHT = 3'd1;
    localparam logic [2:0] REG_CENTER = 3'd2;
    localparam logic [2:0] REG_EDGE   = 3'd3;
    localparam logic [2:0] REG_CORNER = 3'd4;

    localparam logic [23:0] LUMA_R = 24'd13933;
    localparam logic [23:0] LUMA_G = 24'd46871;
    localparam logic [23:0] LUMA_B = 24'd4732;
    localparam logic [ROW_W-1:0] MAX_HEIGHT = 13'd4096;

    typedef struct packed {
        logic gray_en;
        logic top_en;
        logic mid_en;
        logic col0;
        logic emit;
        logic last;
    } s1_ctrl_t;

    logic [COL_W-1:0] width_raw_reg;
    logic [ROW_W-1:0] height_raw_reg;
    logic [15:0]      center_raw_reg;
    logic [15:0]      edge_raw_reg;
    logic [15:0]      corner_raw_reg;

    logic [COL_W-1:0] eff_w;
    logic [ROW_W-1:0] eff_h;

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W:0]   col_inc;
    logic [ROW_W:0]   row_x, h0, h1, h2;

    logic             in_fire;
    s1_ctrl_t         s0_ctrl;
    logic             s0_end;
    logic [AW-1:0]    s0_idx;

    logic             s1_valid_reg;
    s1_ctrl_t         s1_ctrl_reg;
    logic [AW-1:0]    s1_addr_reg;
    logic [7:0]       s1_red_reg, s1_green_reg, s1_blue_reg;
    logic             s1_fire;

    logic [23:0]      luma_sum;
    logic [PIX_W-1:0] gray;
    logic [PIX_W-1:0] rd_upper, rd_middle;
    gcf_col_t         new_col;
    gcf_col_t         cell_l_q, cell_m_q, cell_r_q;
    gcf_win_t         tap;

    logic [31:0]          center_ext, edge_ext, corner_ext;
    logic [COEF_BITS-1:0] center_coef, edge_coef, corner_coef;
    logic                 k_valid, k_ready;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_raw_reg  <= 11'd256;
            height_raw_reg <= 13'd256;
            center_raw_reg <= 16'd9110;
            edge_raw_reg   <= 16'd4565;
            corner_raw_reg <= 16'd1348;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WIDTH:  width_raw_reg  <= cfg_data[COL_W-1:0];
                REG_HEIGHT: height_raw_reg <= cfg_data[ROW_W-1:0];
                REG_CENTER: center_raw_reg <= cfg_data;
                REG_EDGE:   edge_raw_reg   <= cfg_data;
                REG_CORNER: corner_raw_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        priority if (width_raw_reg == '0)
        begin
            eff_w = COL_W'(1);
        end
        else if (32'(width_raw_reg) > 32'(MAX_WIDTH))
        begin
            eff_w = COL_W'(MAX_WIDTH);
        end
        else
        begin
            eff_w = width_raw_reg;
        end
        priority if (height_raw_reg == '0)
        begin
            eff_h = ROW_W'(1);
        end
        else if (height_raw_reg > MAX_HEIGHT)
        begin
            eff_h = MAX_HEIGHT;
        end
        else
        begin
            eff_h = height_raw_reg;
        end
    end

    assign center_ext  = {16'b0, center_raw_reg};
    assign edge_ext    = {16'b0, edge_raw_reg};
    assign corner_ext  = {16'b0, corner_raw_reg};
    assign center_coef = center_ext[COEF_BITS-1:0];
    assign edge_coef   = edge_ext[COEF_BITS-1:0];
    assign corner_coef = corner_ext[COEF_BITS-1:0];

    // stream position decode
    assign s1_fire  = s1_valid_reg && (!s1_ctrl_reg.emit || k_ready);
    assign in_stall = s1_valid_reg && !s1_fire;
    assign in_fire  = in_valid && !in_stall;

    always_comb
    begin
        row_x = {1'b0, row_reg};
        h0    = {1'b0, eff_h};
        h1    = h0 + (ROW_W+1)'(1);
        h2    = h0 + (ROW_W+1)'(2);

        s0_ctrl.gray_en = !action && (row_x < h0);
        s0_ctrl.top_en  = row_reg >= ROW_W'(2);
        s0_ctrl.mid_en  = row_reg >= ROW_W'(1);
        s0_ctrl.col0    = col_reg == '0;
        if (s0_ctrl.col0)
        begin
            s0_ctrl.emit = s0_ctrl.top_en && (row_x < h2);
        end
        else
        begin
            s0_ctrl.emit = s0_ctrl.mid_en && (row_x < h1);
        end
        s0_ctrl.last = s0_ctrl.col0 && s0_ctrl.emit && (row_x == h1);
        s0_end       = s0_ctrl.col0 && (row_x >= h1);

        s0_idx = (32'(col_reg) < 32'(MAX_WIDTH)) ? AW'(col_reg) : '0;

        col_inc = {1'b0, col_reg} + (COL_W+1)'(1);
        if (s0_end)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (col_inc >= {1'b0, eff_w})
        begin
            col_next = '0;
            row_next = row_reg + ROW_W'(1);
        end
        else
        begin
            col_next = col_inc[COL_W-1:0];
            row_next = row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s1_ctrl_reg  <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                col_reg     <= col_next;
                row_reg     <= row_next;
                s1_ctrl_reg <= s0_ctrl;
            end
            if (in_fire || s1_fire)
            begin
                s1_valid_reg <= in_fire;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_addr_reg  <= s0_idx;
            s1_red_reg   <= red;
            s1_green_reg <= green;
            s1_blue_reg  <= blue;
        end
    end

    // luminance and new window column
    always_comb
    begin
        luma_sum = LUMA_R * 24'(s1_red_reg) + LUMA_G * 24'(s1_green_reg)
                 + LUMA_B * 24'(s1_blue_reg);
        gray     = s1_ctrl_reg.gray_en ? luma_sum[23:8] : '0;
        new_col.top = s1_ctrl_reg.top_en ? rd_upper : '0;
        new_col.mid = s1_ctrl_reg.mid_en ? rd_middle : '0;
        new_col.bot = gray;
        tap.l = cell_m_q;
        tap.m = cell_r_q;
        tap.r = s1_ctrl_reg.col0 ? '0 : new_col;
    end

    gcf_line_store #(
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk       (clk),
        .rd_en     (in_fire),
        .rd_addr   (s0_idx),
        .wr_en     (s1_fire),
        .wr_addr   (s1_addr_reg),
        .wr_upper  (rd_middle),
        .wr_middle (gray),
        .rd_upper  (rd_upper),
        .rd_middle (rd_middle)
    );

    gcf_window_cell u_cell_r (
        .clk   (clk),
        .rst_n (rst_n),
        .shift (s1_fire),
        .clear (1'b0),
        .din   (new_col),
        .q     (cell_r_q)
    );

    gcf_window_cell u_cell_m (
        .clk   (clk),
        .rst_n (rst_n),
        .shift (s1_fire),
        .clear (s1_ctrl_reg.col0),
        .din   (cell_r_q),
        .q     (cell_m_q)
    );

    gcf_window_cell u_cell_l (
        .clk   (clk),
        .rst_n (rst_n),
        .shift (s1_fire),
        .clear (s1_ctrl_reg.col0),
        .din   (cell_m_q),
        .q     (cell_l_q)
    );

    assign k_valid = s1_valid_reg && s1_ctrl_reg.emit;

    gcf_kernel #(
        .COEF_BITS (COEF_BITS)
    ) u_kernel (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (k_valid),
        .in_ready       (k_ready),
        .tap            (tap),
        .in_last        (s1_ctrl_reg.last),
        .center_coef    (center_coef),
        .edge_coef      (edge_coef),
        .corner_coef    (corner_coef),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .filtered_value (filtered_value),
        .frame_last     (frame_last)
    );

    property p_frame_wrap;
        @(posedge clk) disable iff (!rst_n)
            in_fire && s0_end |=> (col_reg == '0) && (row_reg == '0);
    endproperty

    property p_emit_hold;
        @(posedge clk) disable iff (!rst_n)
            s1_valid_reg && s1_ctrl_reg.emit && !k_ready |=> s1_valid_reg && s1_ctrl_reg.emit;
    endproperty

    property p_last_emits;
        @(posedge clk) disable iff (!rst_n)
            s1_valid_reg && s1_ctrl_reg.last |-> s1_ctrl_reg.emit;
    endproperty

    property p_window_left_clear;
        @(posedge clk) disable iff (!rst_n)
            s1_fire && s1_ctrl_reg.col0 |=> (cell_l_q == '0) && (cell_m_q == '0);
    endproperty

    a_frame_wrap: assert property (p_frame_wrap)
        else $error("counters not cleared after frame end");
    a_emit_hold: assert property (p_emit_hold)
        else $error("window word lost while kernel busy");
    a_last_emits: assert property (p_last_emits)
        else $error("frame_last marked on a silent word");
    a_window_left_clear: assert property (p_window_left_clear)
        else $error("window not cleared at line start");

endmodule

### sv/gcf_line_store.sv
`timescale 1ns / 1ps
// Two line stores of luminance words, one write and one registered read a cycle.
// A read that meets a write to the same address returns the written word.
// Depends on gcf_pkg.
module gcf_line_store
    import gcf_pkg::*;
#(
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
)
(
    input  logic             clk,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [PIX_W-1:0] wr_upper,
    input  logic [PIX_W-1:0] wr_middle,
    output logic [PIX_W-1:0] rd_upper,
    output logic [PIX_W-1:0] rd_middle
);

    logic [PIX_W-1:0] upper_mem [DEPTH];
    logic [PIX_W-1:0] middle_mem [DEPTH];
    logic [PIX_W-1:0] upper_q_reg;
    logic [PIX_W-1:0] middle_q_reg;
    logic [PIX_W-1:0] fwd_upper_reg;
    logic [PIX_W-1:0] fwd_middle_reg;
    logic             fwd_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            upper_mem[wr_addr]  <= wr_upper;
            middle_mem[wr_addr] <= wr_middle;
        end
        if (rd_en)
        begin
            upper_q_reg    <= upper_mem[rd_addr];
            middle_q_reg   <= middle_mem[rd_addr];
            fwd_reg        <= wr_en && (wr_addr == rd_addr);
            fwd_upper_reg  <= wr_upper;
            fwd_middle_reg <= wr_middle;
        end
    end

    assign rd_upper  = fwd_reg ? fwd_upper_reg : upper_q_reg;
    assign rd_middle = fwd_reg ? fwd_middle_reg : middle_q_reg;

endmodule

### sv/gcf_window_cell.sv
`timescale 1ns / 1ps
// One column cell of the 3x3 window chain: loads its neighbor's column or clears.
// Depends on gcf_pkg.
module gcf_window_cell
    import gcf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     shift,
    input  logic     clear,
    input  gcf_col_t din,
    output gcf_col_t q
);

    gcf_col_t q_reg;
    gcf_col_t q_next;

    always_comb
    begin
        q_next = clear ? '0 : din;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= '0;
        end
        else if (shift)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

### sv/gcf_kernel.sv
`timescale 1ns / 1ps
// Symmetric 3x3 kernel: neighbor sums, coefficient products, clamp to 0..255.
// Four registered stages with valid/ready back-pressure. Depends on gcf_pkg.
module gcf_kernel
    import gcf_pkg::*;
#(
    parameter int COEF_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  gcf_win_t             tap,
    input  logic                 in_last,
    input  logic [COEF_BITS-1:0] center_coef,
    input  logic [COEF_BITS-1:0] edge_coef,
    input  logic [COEF_BITS-1:0] corner_coef,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [7:0]           filtered_value,
    output logic                 frame_last
);

    localparam int SUM_W = PIX_W + 2;
    localparam int PW    = COEF_BITS + SUM_W + 1;
    localparam int CPW   = COEF_BITS + PIX_W + 1;
    localparam int SW    = PW + 2;
    localparam int SH    = COEF_BITS + 7;
    localparam int VW    = SW - SH;

    logic a_ready, b_ready, c_ready, d_ready;

    logic     a_valid_reg;
    gcf_win_t a_tap_reg;
    logic     a_last_reg;

    logic             b_valid_reg;
    logic [PIX_W-1:0] b_center_reg;
    logic [SUM_W-1:0] b_edge_reg;
    logic [SUM_W-1:0] b_corner_reg;
    logic             b_last_reg;
    logic [SUM_W-1:0] b_edge_next;
    logic [SUM_W-1:0] b_corner_next;

    logic                 c_valid_reg;
    logic signed [PW-1:0] c_prod_c_reg;
    logic signed [PW-1:0] c_prod_e_reg;
    logic signed [PW-1:0] c_prod_k_reg;
    logic                 c_last_reg;
    logic signed [CPW-1:0] prod_c_raw;
    logic signed [PW-1:0] c_prod_c_next;
    logic signed [PW-1:0] c_prod_e_next;
    logic signed [PW-1:0] c_prod_k_next;

    logic signed [SW-1:0] total;
    logic [VW-1:0]        scaled;
    logic [7:0]           out_value_next;
    logic                 out_valid_reg;
    logic [7:0]           out_value_reg;
    logic                 out_last_reg;

    assign d_ready  = !out_valid_reg || !out_stall;
    assign c_ready  = !c_valid_reg || d_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    always_comb
    begin
        b_edge_next = SUM_W'(a_tap_reg.l.mid) + SUM_W'(a_tap_reg.m.top)
                    + SUM_W'(a_tap_reg.m.bot) + SUM_W'(a_tap_reg.r.mid);
        b_corner_next = SUM_W'(a_tap_reg.l.top) + SUM_W'(a_tap_reg.l.bot)
                      + SUM_W'(a_tap_reg.r.top) + SUM_W'(a_tap_reg.r.bot);
    end

    always_comb
    begin
        prod_c_raw    = $signed(center_coef) * $signed({1'b0, b_center_reg});
        c_prod_c_next = {{(PW-CPW){prod_c_raw[CPW-1]}}, prod_c_raw};
        c_prod_e_next = $signed(edge_coef) * $signed({1'b0, b_edge_reg});
        c_prod_k_next = $signed(corner_coef) * $signed({1'b0, b_corner_reg});
    end

    always_comb
    begin
        total = {{2{c_prod_c_reg[PW-1]}}, c_prod_c_reg}
              + {{2{c_prod_e_reg[PW-1]}}, c_prod_e_reg}
              + {{2{c_prod_k_reg[PW-1]}}, c_prod_k_reg};
        scaled = total[SW-1:SH];
        if (total[SW-1] || (total == '0))
        begin
            out_value_next = '0;
        end
        else if (|scaled[VW-1:8])
        begin
            out_value_next = PIX_MAX;
        end
        else
        begin
            out_value_next = scaled[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready)
            begin
                c_valid_reg <= b_valid_reg;
            end
            if (d_ready)
            begin
                out_valid_reg <= c_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && a_ready)
        begin
            a_tap_reg  <= tap;
            a_last_reg <= in_last;
        end
        if (a_valid_reg && b_ready)
        begin
            b_center_reg <= a_tap_reg.m.mid;
            b_edge_reg   <= b_edge_next;
            b_corner_reg <= b_corner_next;
            b_last_reg   <= a_last_reg;
        end
        if (b_valid_reg && c_ready)
        begin
            c_prod_c_reg <= c_prod_c_next;
            c_prod_e_reg <= c_prod_e_next;
            c_prod_k_reg <= c_prod_k_next;
            c_last_reg   <= b_last_reg;
        end
        if (c_valid_reg && d_ready)
        begin
            out_value_reg <= out_value_next;
            out_last_reg  <= c_last_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign filtered_value = out_value_reg;
    assign frame_last     = out_last_reg;

    property p_hold_out;
        @(posedge clk) disable iff (!rst_n)
            out_valid_reg && out_stall |=> out_valid_reg;
    endproperty

    property p_stage_hold;
        @(posedge clk) disable iff (!rst_n)
            c_valid_reg && !d_ready |=> c_valid_reg;
    endproperty

    property p_ready_when_empty;
        @(posedge clk) disable iff (!rst_n)
            !a_valid_reg && !b_valid_reg && !c_valid_reg |-> in_ready;
    endproperty

    a_hold_out: assert property (p_hold_out)
        else $error("result dropped while stalled");
    a_stage_hold: assert property (p_stage_hold)
        else $error("product stage lost a word");
    a_ready_when_empty: assert property (p_ready_when_empty)
        else $error("empty kernel refuses a word");

endmodule
